FILE: rtl/core/arqws_pkg.sv
// arqws_pkg: types, codes and fixed widths shared by the arq window sender
// used by arqws_timer_bank and arq_window_sender; depends on nothing
package arqws_pkg;

    // fixed field widths; sequence numbers count modulo 8 by 3-bit wrap
    localparam int SEQ_W     = 3;
    localparam int DATA_W    = 32;
    localparam int TIMER_W   = 8;
    localparam int WIN_W     = 3;
    localparam int EV_W      = 3;
    localparam int ACT_W     = 2;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SLOTS     = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_OFFER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NAK   = 2'd3;

    // event codes
    localparam logic [EV_W-1:0] EV_SENT_NEW    = 3'd0;
    localparam logic [EV_W-1:0] EV_REFUSED     = 3'd1;
    localparam logic [EV_W-1:0] EV_TIMEOUT     = 3'd2;
    localparam logic [EV_W-1:0] EV_ACK_SLID    = 3'd3;
    localparam logic [EV_W-1:0] EV_ACK_IGNORED = 3'd4;
    localparam logic [EV_W-1:0] EV_NAK_RESEND  = 3'd5;
    localparam logic [EV_W-1:0] EV_NAK_IGNORED = 3'd6;
    localparam logic [EV_W-1:0] EV_IDLE_TICK   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    // retransmission modes
    localparam logic MODE_GBN = 1'b0;
    localparam logic MODE_SEL = 1'b1;

    // configuration reset values
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd10;
    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECR,
        ST_SCAN,
        ST_GBN,
        ST_SLIDE
    } state_t;

    typedef enum logic [1:0] {
        TOP_NONE,
        TOP_DEC,
        TOP_LOAD,
        TOP_CLEAR
    } timer_op_t;

    typedef struct packed {
        timer_op_t        op;
        logic [SEQ_W-1:0] addr;
    } timer_cmd_t;

    typedef struct packed {
        logic running;
        logic zero;
    } timer_stat_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SEQ_W-1:0]  ack_number;
        logic [DATA_W-1:0] payload_in;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] payload_out;
        logic [SEQ_W-1:0]  outstanding;
        logic              last;
    } result_t;

endpackage

FILE: rtl/core/arqws_timer_bank.sv
// arqws_timer_bank: per-slot retransmit timers with one shared
// decrement / reload / clear unit; depends on arqws_pkg
module arqws_timer_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  arqws_pkg::timer_cmd_t            cmd,
    input  logic [arqws_pkg::TIMER_W-1:0]    reload,
    output arqws_pkg::timer_stat_t           status
);

    logic [arqws_pkg::TIMER_W-1:0] count_reg [arqws_pkg::SLOTS];
    logic [arqws_pkg::SLOTS-1:0]   running_reg;
    logic [arqws_pkg::TIMER_W-1:0] count_cur;
    logic [arqws_pkg::TIMER_W-1:0] count_next;
    logic                          running_next;
    logic                          count_we;

    // status of the addressed slot
    assign count_cur      = count_reg[cmd.addr];
    assign status.running = running_reg[cmd.addr];
    assign status.zero    = (count_cur == '0);

    // shared update unit
    always_comb
    begin
        count_next   = count_cur;
        running_next = running_reg[cmd.addr];
        count_we     = 1'b0;
        case (cmd.op)
            arqws_pkg::TOP_DEC:
            begin
                if (running_reg[cmd.addr] && (count_cur != '0))
                begin
                    count_next = count_cur - 1'b1;
                    count_we   = 1'b1;
                end
            end
            arqws_pkg::TOP_LOAD:
            begin
                count_next   = reload;
                running_next = 1'b1;
                count_we     = 1'b1;
            end
            arqws_pkg::TOP_CLEAR:
            begin
                count_next   = '0;
                running_next = 1'b0;
                count_we     = 1'b1;
            end
            default:
            begin
                count_we = 1'b0;
            end
        endcase
    end

    // timer storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            for (int k = 0; k < arqws_pkg::SLOTS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (count_we)
        begin
            count_reg[cmd.addr]   <= count_next;
            running_reg[cmd.addr] <= running_next;
        end
    end

endmodule

FILE: rtl/core/arq_window_sender.sv
// arq_window_sender: top level of the sliding-window arq sender
// depends on arqws_pkg and arqws_timer_bank
//
// usage: a transaction enters on item when start is high and busy is low.
// item.action selects offer, tick, ack or nak. every transaction gives one
// or more results on result, each shown for one cycle with result_strobe
// high; result.last marks the final one. the receiver cannot stall.
// sequencing per transaction kind:
//   offer, nak, ignored ack: result in the cycle after the transaction, busy
//     stays low, so one of these per cycle
//   sliding ack freeing k slots: busy while they are cleared one by one, result
//     in the cycle after the last busy cycle
//   tick: timer decrement of every slot through the shared timer unit, then a
//     scan of one outstanding slot per cycle; go-back-n then resends every
//     outstanding frame, results one per cycle during the resend
// the timer unit and the single payload read port serialise these steps.
// configuration (mode, timer reload, window limit) is written through
// cfg_wr_en / cfg_index / cfg_data; the user must do so only while idle,
// as the block itself does not enforce it.
// reset clears sequence state, timers and configuration to defaults; the
// payload memory is not cleared and is read only for outstanding slots.
module arq_window_sender (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  arqws_pkg::item_t                    item,
    output logic                                result_strobe,
    output arqws_pkg::result_t                  result,
    input  logic                                cfg_wr_en,
    input  logic [arqws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arqws_pkg::CFG_W-1:0]         cfg_data
);

    // configuration
    logic                            mode_reg;
    logic [arqws_pkg::TIMER_W-1:0]   timeout_reg;
    logic [arqws_pkg::WIN_W-1:0]     window_reg;

    // sequencer and window state
    arqws_pkg::state_t               state_reg, state_next;
    logic [arqws_pkg::SEQ_W-1:0]     next_seq_reg, next_seq_next;
    logic [arqws_pkg::SEQ_W-1:0]     base_reg, base_next;
    logic [arqws_pkg::SEQ_W-1:0]     cnt_reg, cnt_next;
    logic [arqws_pkg::SEQ_W-1:0]     idx_reg, idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [arqws_pkg::SEQ_W-1:0]     pend_seq_reg, pend_seq_next;

    // result stage
    logic                            strobe_reg, strobe_next;
    arqws_pkg::result_t              result_reg, result_next;
    logic                            res_from_mem;
    logic [arqws_pkg::SEQ_W-1:0]     rd_addr;

    // payload memory
    logic [arqws_pkg::DATA_W-1:0]    payload_mem [arqws_pkg::SLOTS];
    logic                            mem_we;

    // timer unit
    arqws_pkg::timer_cmd_t           tcmd;
    arqws_pkg::timer_stat_t          tstat;

    logic [arqws_pkg::SEQ_W-1:0]     slot;
    logic [arqws_pkg::SEQ_W-1:0]     ack_off;
    logic                            expired;

    arqws_timer_bank u_timer_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (tcmd),
        .reload (timeout_reg),
        .status (tstat)
    );

    assign slot    = base_reg + idx_reg;
    assign ack_off = item.ack_number - base_reg;
    assign expired = tstat.running && tstat.zero;

    assign busy          = (state_reg != arqws_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= arqws_pkg::MODE_GBN;
            timeout_reg <= arqws_pkg::TIMEOUT_RESET;
            window_reg  <= arqws_pkg::WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                arqws_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                arqws_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                arqws_pkg::CFG_WINDOW:  window_reg  <= cfg_data[arqws_pkg::WIN_W-1:0];
                default:                mode_reg    <= mode_reg;
            endcase
        end
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        next_seq_next   = next_seq_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        strobe_next     = 1'b0;
        result_next     = '0;
        res_from_mem    = 1'b0;
        rd_addr         = '0;
        mem_we          = 1'b0;
        tcmd.op         = arqws_pkg::TOP_NONE;
        tcmd.addr       = '0;

        case (state_reg)
            arqws_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (item.action)
                        arqws_pkg::ACT_OFFER:
                        begin
                            strobe_next      = 1'b1;
                            result_next.last = 1'b1;
                            if (cnt_reg < window_reg)
                            begin
                                mem_we                  = 1'b1;
                                tcmd.op                 = arqws_pkg::TOP_LOAD;
                                tcmd.addr               = next_seq_reg;
                                next_seq_next           = next_seq_reg + 1'b1;
                                cnt_next                = cnt_reg + 1'b1;
                                result_next.event_res   = arqws_pkg::EV_SENT_NEW;
                                result_next.seq         = next_seq_reg;
                                result_next.payload_out = item.payload_in;
                                result_next.outstanding = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                result_next.event_res   = arqws_pkg::EV_REFUSED;
                                result_next.outstanding = cnt_reg;
                            end
                        end
                        arqws_pkg::ACT_TICK:
                        begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = arqws_pkg::ST_DECR;
                        end
                        arqws_pkg::ACT_ACK:
                        begin
                            if (ack_off < cnt_reg)
                            begin
                                idx_next   = ack_off;
                                state_next = arqws_pkg::ST_SLIDE;
                            end
                            else
                            begin
                                strobe_next             = 1'b1;
                                result_next.event_res   = arqws_pkg::EV_ACK_IGNORED;
                                result_next.outstanding = cnt_reg;
                                result_next.last        = 1'b1;
                            end
                        end
                        default:
                        begin
                            strobe_next             = 1'b1;
                            result_next.outstanding = cnt_reg;
                            result_next.last        = 1'b1;
                            if ((mode_reg == arqws_pkg::MODE_SEL) && (ack_off < cnt_reg))
                            begin
                                tcmd.op               = arqws_pkg::TOP_LOAD;
                                tcmd.addr             = item.ack_number;
                                result_next.event_res = arqws_pkg::EV_NAK_RESEND;
                                result_next.seq       = item.ack_number;
                                res_from_mem          = 1'b1;
                                rd_addr               = item.ack_number;
                            end
                            else
                            begin
                                result_next.event_res = arqws_pkg::EV_NAK_IGNORED;
                            end
                        end
                    endcase
                end
            end

            // decrement every running timer, one slot a cycle
            arqws_pkg::ST_DECR:
            begin
                tcmd.op   = arqws_pkg::TOP_DEC;
                tcmd.addr = idx_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == arqws_pkg::SEQ_W'(arqws_pkg::SLOTS - 1))
                begin
                    state_next = arqws_pkg::ST_SCAN;
                end
            end

            // walk outstanding slots from the window base looking for expiry
            arqws_pkg::ST_SCAN:
            begin
                tcmd.addr = slot;
                if (idx_reg == cnt_reg)
                begin
                    strobe_next             = 1'b1;
                    result_next.outstanding = cnt_reg;
                    result_next.last        = 1'b1;
                    state_next              = arqws_pkg::ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        result_next.event_res = arqws_pkg::EV_TIMEOUT;
                        result_next.seq       = pend_seq_reg;
                        res_from_mem          = 1'b1;
                        rd_addr               = pend_seq_reg;
                    end
                    else
                    begin
                        result_next.event_res = arqws_pkg::EV_IDLE_TICK;
                    end
                end
                else if (expired && (mode_reg == arqws_pkg::MODE_GBN))
                begin
                    idx_next   = '0;
                    state_next = arqws_pkg::ST_GBN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (expired)
                    begin
                        tcmd.op         = arqws_pkg::TOP_LOAD;
                        pend_valid_next = 1'b1;
                        pend_seq_next   = slot;
                        // the earlier expiry is known not to be the final one
                        if (pend_valid_reg)
                        begin
                            strobe_next             = 1'b1;
                            result_next.event_res   = arqws_pkg::EV_TIMEOUT;
                            result_next.seq         = pend_seq_reg;
                            result_next.outstanding = cnt_reg;
                            res_from_mem            = 1'b1;
                            rd_addr                 = pend_seq_reg;
                        end
                    end
                end
            end

            // go-back-n: resend every outstanding frame in order
            arqws_pkg::ST_GBN:
            begin
                tcmd.op                 = arqws_pkg::TOP_LOAD;
                tcmd.addr               = slot;
                strobe_next             = 1'b1;
                result_next.event_res   = arqws_pkg::EV_TIMEOUT;
                result_next.seq         = slot;
                result_next.outstanding = cnt_reg;
                res_from_mem            = 1'b1;
                rd_addr                 = slot;
                idx_next                = idx_reg + 1'b1;
                if (idx_reg == (cnt_reg - 1'b1))
                begin
                    result_next.last = 1'b1;
                    state_next       = arqws_pkg::ST_IDLE;
                end
            end

            // cumulative ack: free one slot a cycle
            arqws_pkg::ST_SLIDE:
            begin
                tcmd.op   = arqws_pkg::TOP_CLEAR;
                tcmd.addr = base_reg;
                base_next = base_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                idx_next  = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    strobe_next             = 1'b1;
                    result_next.event_res   = arqws_pkg::EV_ACK_SLID;
                    result_next.outstanding = cnt_reg - 1'b1;
                    result_next.last        = 1'b1;
                    state_next              = arqws_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = arqws_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer and window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arqws_pkg::ST_IDLE;
            next_seq_reg   <= '0;
            base_reg       <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            base_reg       <= base_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload memory and result register
    always_ff @(posedge clk)
    begin
        pend_seq_reg <= pend_seq_next;
        if (mem_we)
        begin
            payload_mem[next_seq_reg] <= item.payload_in;
        end
        if (res_from_mem)
        begin
            result_reg <= '{event_res:   result_next.event_res,
                            seq:         result_next.seq,
                            payload_out: payload_mem[rd_addr],
                            outstanding: result_next.outstanding,
                            last:        result_next.last};
        end
        else
        begin
            result_reg <= result_next;
        end
    end

    // the window always spans exactly the outstanding frames
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_seq_reg - base_reg) == cnt_reg)
    else $error("window span does not match outstanding count");

    // the sequencer ends every long transaction with a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_strobe && result.last))
    else $error("sequencer returned to idle without a final result");

    // non-final results only come from a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
    else $error("non-final result while idle");

    // a timeout resend always names an outstanding slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.event_res == arqws_pkg::EV_TIMEOUT))
            |-> ((result.seq - base_reg) < cnt_reg))
    else $error("timeout resend outside the window");

endmodule

FILE: verif/tb_arq_window_sender.sv
// tb_arq_window_sender: self-checking testbench for the arq window sender
// depends on arqws_pkg and the arq_window_sender rtl; drives offers, ticks, acks
// and naks and checks every result against a cycle-free window model or typed-in values
`timescale 1ns / 100ps

module tb_arq_window_sender;

    typedef struct {
        bit                              is_cfg;
        logic [arqws_pkg::CFG_IDX_W-1:0] idx;
        logic [arqws_pkg::CFG_W-1:0]     val;
        arqws_pkg::item_t                it;
        bit                              typed;
        arqws_pkg::result_t              want;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    arqws_pkg::item_t                item;
    logic                            result_strobe;
    arqws_pkg::result_t              result;
    logic                            cfg_wr_en;
    logic [arqws_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [arqws_pkg::CFG_W-1:0]     cfg_data;

    // window model: configuration copy and sender state
    logic                            m_mode;
    logic [arqws_pkg::TIMER_W-1:0]   m_timeout;
    logic [arqws_pkg::WIN_W-1:0]     m_window;
    logic [arqws_pkg::SEQ_W-1:0]     m_next;
    logic [arqws_pkg::SEQ_W-1:0]     m_base;
    int unsigned                     m_count;
    logic [arqws_pkg::TIMER_W-1:0]   m_timer [arqws_pkg::SLOTS];
    bit                              m_run [arqws_pkg::SLOTS];
    logic [arqws_pkg::DATA_W-1:0]    m_pay [arqws_pkg::SLOTS];

    arqws_pkg::result_t              step_events[$];
    arqws_pkg::result_t              awaited_events[$];
    stim_row_t                       stim_rows[$];

    bit                              exp_typed_en;
    arqws_pkg::result_t              exp_typed;
    arqws_pkg::result_t              pred_r;
    int                              gap_pct;
    int unsigned                     errors;
    int unsigned                     n_accepted;
    int unsigned                     n_effective;
    int unsigned                     n_checked;
    int unsigned                     n_random;

    arq_window_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_err(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic reset_window_model();
        m_mode    = arqws_pkg::MODE_GBN;
        m_timeout = arqws_pkg::TIMEOUT_RESET;
        m_window  = arqws_pkg::WINDOW_RESET;
        m_next    = '0;
        m_base    = '0;
        m_count   = 0;
        for (int i = 0; i < arqws_pkg::SLOTS; i++)
        begin
            m_timer[i] = '0;
            m_run[i]   = 1'b0;
            m_pay[i]   = '0;
        end
    endtask

    function automatic void add_event(logic [arqws_pkg::EV_W-1:0] ev,
                                      logic [arqws_pkg::SEQ_W-1:0] sq,
                                      logic [arqws_pkg::DATA_W-1:0] pl);
        arqws_pkg::result_t r;
        r.event_res   = ev;
        r.seq         = sq;
        r.payload_out = pl;
        r.outstanding = m_count[arqws_pkg::SEQ_W-1:0];
        r.last        = 1'b0;
        step_events.insert(step_events.size(), r);
    endfunction

    // advance the window model by one transaction, results land in step_events
    task automatic step_window(input arqws_pkg::item_t it);
        logic [arqws_pkg::SEQ_W-1:0] ack_off;
        logic [arqws_pkg::SEQ_W-1:0] s;
        logic [arqws_pkg::SEQ_W-1:0] t;
        step_events.delete();
        ack_off = it.ack_number - m_base;
        case (it.action)
            arqws_pkg::ACT_OFFER:
            begin
                if (m_count < m_window)
                begin
                    s = m_next;
                    m_pay[s]   = it.payload_in;
                    m_timer[s] = m_timeout;
                    m_run[s]   = 1'b1;
                    m_next     = m_next + 1'b1;
                    m_count++;
                    add_event(arqws_pkg::EV_SENT_NEW, s, it.payload_in);
                end
                else
                    add_event(arqws_pkg::EV_REFUSED, '0, '0);
            end
            arqws_pkg::ACT_TICK:
            begin
                for (int i = 0; i < arqws_pkg::SLOTS; i++)
                    if (m_run[i] && m_timer[i] > 0)
                        m_timer[i] = m_timer[i] - 1'b1;
                for (int j = 0; j < m_count; j++)
                begin
                    s = m_base + j[arqws_pkg::SEQ_W-1:0];
                    if (m_run[s] && m_timer[s] == 0)
                    begin
                        if (m_mode == arqws_pkg::MODE_GBN)
                        begin
                            // go-back-n: resend the whole window in order
                            step_events.delete();
                            for (int k = 0; k < m_count; k++)
                            begin
                                t = m_base + k[arqws_pkg::SEQ_W-1:0];
                                m_timer[t] = m_timeout;
                                m_run[t]   = 1'b1;
                                add_event(arqws_pkg::EV_TIMEOUT, t, m_pay[t]);
                            end
                            break;
                        end
                        m_timer[s] = m_timeout;
                        add_event(arqws_pkg::EV_TIMEOUT, s, m_pay[s]);
                    end
                end
                if (step_events.size() == 0)
                    add_event(arqws_pkg::EV_IDLE_TICK, '0, '0);
            end
            arqws_pkg::ACT_ACK:
            begin
                if (ack_off < m_count)
                begin
                    for (int j = 0; j <= ack_off; j++)
                    begin
                        m_run[m_base]   = 1'b0;
                        m_timer[m_base] = '0;
                        m_base          = m_base + 1'b1;
                        m_count--;
                    end
                    add_event(arqws_pkg::EV_ACK_SLID, '0, '0);
                end
                else
                    add_event(arqws_pkg::EV_ACK_IGNORED, '0, '0);
            end
            default:
            begin
                if (m_mode == arqws_pkg::MODE_SEL && ack_off < m_count)
                begin
                    m_timer[it.ack_number] = m_timeout;
                    m_run[it.ack_number]   = 1'b1;
                    add_event(arqws_pkg::EV_NAK_RESEND, it.ack_number,
                              m_pay[it.ack_number]);
                end
                else
                    add_event(arqws_pkg::EV_NAK_IGNORED, '0, '0);
            end
        endcase
    endtask

    task automatic check_result(input arqws_pkg::result_t got);
        arqws_pkg::result_t want;
        if (awaited_events.size() == 0)
            report_err($sformatf("unexpected result event %0d seq %0d",
                                 got.event_res, got.seq));
        else
        begin
            want = awaited_events.pop_front();
            n_checked++;
            if (got.event_res !== want.event_res)
                report_err($sformatf("event_res got %0d want %0d", got.event_res,
                                     want.event_res));
            if (got.seq !== want.seq)
                report_err($sformatf("seq got %0d want %0d", got.seq, want.seq));
            if (got.payload_out !== want.payload_out)
                report_err($sformatf("payload_out got %h want %h", got.payload_out,
                                     want.payload_out));
            if (got.outstanding !== want.outstanding)
                report_err($sformatf("outstanding got %0d want %0d", got.outstanding,
                                     want.outstanding));
            if (got.last !== want.last)
                report_err($sformatf("last got %0d want %0d", got.last, want.last));
        end
    endtask

    // monitor: register writes, accepted transactions and results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    arqws_pkg::CFG_MODE:    m_mode    = cfg_data[0];
                    arqws_pkg::CFG_TIMEOUT: m_timeout = cfg_data[arqws_pkg::TIMER_W-1:0];
                    arqws_pkg::CFG_WINDOW:  m_window  = cfg_data[arqws_pkg::WIN_W-1:0];
                    default:                ;
                endcase
            end
            if (start && !busy)
            begin
                step_window(item);
                n_accepted++;
                if (step_events[0].event_res != arqws_pkg::EV_ACK_IGNORED &&
                    step_events[0].event_res != arqws_pkg::EV_NAK_IGNORED)
                    n_effective++;
                if (exp_typed_en)
                    awaited_events.insert(awaited_events.size(), exp_typed);
                else
                    for (int r = 0; r < step_events.size(); r++)
                    begin
                        pred_r      = step_events[r];
                        pred_r.last = (r == step_events.size() - 1);
                        awaited_events.insert(awaited_events.size(), pred_r);
                    end
            end
            if (result_strobe)
                check_result(result);
        end
    end

    // stimulus rows: register writes, predicted transactions, typed-in transactions
    function automatic void row_cfg(logic [arqws_pkg::CFG_IDX_W-1:0] idx,
                                    logic [arqws_pkg::CFG_W-1:0] val);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.it     = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void row_item(logic [arqws_pkg::ACT_W-1:0] act,
                                     logic [arqws_pkg::SEQ_W-1:0] ack,
                                     logic [arqws_pkg::DATA_W-1:0] pay);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.it     = '{action: act, ack_number: ack, payload_in: pay};
        r.typed  = 1'b0;
        r.want   = '0;
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    function automatic void row_chk(logic [arqws_pkg::ACT_W-1:0] act,
                                    logic [arqws_pkg::SEQ_W-1:0] ack,
                                    logic [arqws_pkg::DATA_W-1:0] pay,
                                    logic [arqws_pkg::EV_W-1:0] ev,
                                    logic [arqws_pkg::SEQ_W-1:0] sq,
                                    logic [arqws_pkg::DATA_W-1:0] po,
                                    logic [arqws_pkg::SEQ_W-1:0] outst);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.it     = '{action: act, ack_number: ack, payload_in: pay};
        r.typed  = 1'b1;
        r.want   = '{event_res: ev, seq: sq, payload_out: po, outstanding: outst,
                     last: 1'b1};
        stim_rows.insert(stim_rows.size(), r);
    endfunction

    // wait until every result has arrived and busy is low, then pad with idle clocks
    task automatic wait_idle();
        while (awaited_events.size() != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [arqws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arqws_pkg::CFG_W-1:0] val);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // one transaction: optional gap, then hold start until busy is low at an edge
    task automatic send_item(input arqws_pkg::item_t it, input bit typed,
                             input arqws_pkg::result_t want);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item         = it;
        exp_typed_en = typed;
        exp_typed    = want;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    // random transaction: offers, ticks, and acks and naks that mostly land inside the window
    task automatic random_item(output arqws_pkg::item_t it);
        int unsigned pick;
        logic [arqws_pkg::SEQ_W-1:0] off;
        pick          = $urandom_range(0, 99);
        it.payload_in = $urandom;
        it.ack_number = arqws_pkg::SEQ_W'($urandom_range(0, 7));
        if (pick < 40)
            it.action = arqws_pkg::ACT_OFFER;
        else if (pick < 70)
            it.action = arqws_pkg::ACT_TICK;
        else
        begin
            it.action = (pick < 88) ? arqws_pkg::ACT_ACK : arqws_pkg::ACT_NAK;
            if (m_count > 0 && $urandom_range(0, 3) != 0)
            begin
                off           = arqws_pkg::SEQ_W'($urandom_range(0, m_count - 1));
                it.ack_number = m_base + off;
            end
        end
    endtask

    initial
    begin
        int unsigned ph_mode [6]    = '{1, 0, 1, 0, 1, 0};
        int unsigned ph_timeout [6] = '{3, 2, 1, 255, 0, 4};
        int unsigned ph_window [6]  = '{4, 7, 1, 3, 7, 5};
        int unsigned guard;
        arqws_pkg::item_t it;

        start        = 1'b0;
        item         = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        exp_typed_en = 1'b0;
        exp_typed    = '0;
        pred_r       = '0;
        gap_pct      = 18;
        errors       = 0;
        n_accepted   = 0;
        n_effective  = 0;
        n_checked    = 0;
        n_random     = 0;
        reset_window_model();
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part: empty window, fill to the limit, go-back-n and selective
        row_chk(arqws_pkg::ACT_TICK, 3'd0, 32'h0, arqws_pkg::EV_IDLE_TICK,
                3'd0, 32'h0, 3'd0);
        row_chk(arqws_pkg::ACT_ACK, 3'd0, 32'h0, arqws_pkg::EV_ACK_IGNORED,
                3'd0, 32'h0, 3'd0);
        row_chk(arqws_pkg::ACT_NAK, 3'd7, 32'h0, arqws_pkg::EV_NAK_IGNORED,
                3'd0, 32'h0, 3'd0);
        row_chk(arqws_pkg::ACT_OFFER, 3'd0, 32'h0000_0000, arqws_pkg::EV_SENT_NEW,
                3'd0, 32'h0000_0000, 3'd1);
        row_chk(arqws_pkg::ACT_OFFER, 3'd7, 32'hFFFF_FFFF, arqws_pkg::EV_SENT_NEW,
                3'd1, 32'hFFFF_FFFF, 3'd2);
        row_item(arqws_pkg::ACT_OFFER, 3'd5, 32'hA5A5_5A5A);
        row_item(arqws_pkg::ACT_OFFER, 3'd2, 32'h1234_5678);
        row_item(arqws_pkg::ACT_OFFER, 3'd0, 32'h8000_0001);
        row_item(arqws_pkg::ACT_OFFER, 3'd0, 32'h7FFF_FFFE);
        // window full
        row_chk(arqws_pkg::ACT_OFFER, 3'd0, 32'hDEAD_BEEF, arqws_pkg::EV_REFUSED,
                3'd0, 32'h0, 3'd6);
        row_chk(arqws_pkg::ACT_NAK, 3'd2, 32'h0, arqws_pkg::EV_NAK_IGNORED,
                3'd0, 32'h0, 3'd6);
        // ack outside the window, then a cumulative slide of two
        row_chk(arqws_pkg::ACT_ACK, 3'd7, 32'h0, arqws_pkg::EV_ACK_IGNORED,
                3'd0, 32'h0, 3'd6);
        row_chk(arqws_pkg::ACT_ACK, 3'd1, 32'h0, arqws_pkg::EV_ACK_SLID,
                3'd0, 32'h0, 3'd4);
        // go-back-n expiry resends the whole window
        row_cfg(arqws_pkg::CFG_TIMEOUT, 8'd1);
        row_item(arqws_pkg::ACT_OFFER, 3'd0, 32'h0F0F_0F0F);
        row_item(arqws_pkg::ACT_TICK,  3'd0, 32'h0);
        // selective repeat with a zero timeout: every tick resends everything
        row_cfg(arqws_pkg::CFG_MODE, 8'(arqws_pkg::MODE_SEL));
        row_cfg(arqws_pkg::CFG_TIMEOUT, 8'd0);
        row_item(arqws_pkg::ACT_NAK, 3'd3, 32'h0);
        row_chk(arqws_pkg::ACT_NAK, 3'd0, 32'h0, arqws_pkg::EV_NAK_IGNORED,
                3'd0, 32'h0, 3'd5);
        row_item(arqws_pkg::ACT_TICK, 3'd0, 32'h0);
        row_item(arqws_pkg::ACT_TICK, 3'd0, 32'h0);
        row_chk(arqws_pkg::ACT_ACK, 3'd6, 32'h0, arqws_pkg::EV_ACK_SLID,
                3'd0, 32'h0, 3'd0);
        // zero window refuses every offer
        row_cfg(arqws_pkg::CFG_WINDOW, 8'd0);
        row_chk(arqws_pkg::ACT_OFFER, 3'd4, 32'h5555_AAAA, arqws_pkg::EV_REFUSED,
                3'd0, 32'h0, 3'd0);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].is_cfg)
                write_cfg(stim_rows[k].idx, stim_rows[k].val);
            else
                send_item(stim_rows[k].it, stim_rows[k].typed, stim_rows[k].want);
        end

        // random phases, each with its own register setting; pairs of phases share a gap profile
        for (int p = 0; p < 6; p++)
        begin
            write_cfg(arqws_pkg::CFG_MODE, 8'(ph_mode[p]));
            write_cfg(arqws_pkg::CFG_TIMEOUT, 8'(ph_timeout[p]));
            write_cfg(arqws_pkg::CFG_WINDOW, 8'(ph_window[p]));
            gap_pct = (p < 2) ? 18 : (p < 4) ? 72 : 0;
            for (int n = 0; n < 43; n++)
            begin
                random_item(it);
                send_item(it, 1'b0, '0);
                n_random++;
            end
        end

        // drain
        guard = 0;
        while (awaited_events.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (30) @(negedge clk);
        if (awaited_events.size() != 0)
            report_err($sformatf("%0d expected results never arrived",
                                 awaited_events.size()));

        $display("run covered %0d transactions (%0d random, %0d not ignored)",
                 n_accepted, n_random, n_effective);
        $display("%0d results compared, %0d mismatches", n_checked, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: arq_window_sender.f
rtl/core/arqws_pkg.sv
rtl/core/arqws_timer_bank.sv
rtl/core/arq_window_sender.sv
verif/tb_arq_window_sender.sv
